// ===== src/smfd_pkg.sv =====
`timescale 1ns / 1ps
// shared types, fixed-point constants and the control program of the stereo echo
package smfd_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int DELAY_BITS     = 14;
    localparam int COEF_BITS      = 16;
    localparam int FRAC_BITS      = 16;
    localparam int OPA_BITS       = SAMPLE_BITS + 1;
    localparam int PROD_BITS      = OPA_BITS + COEF_BITS + 1;
    localparam int RND_BITS       = PROD_BITS - FRAC_BITS;
    localparam int SUM_BITS       = RND_BITS + 1;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;

    // weights in unsigned Q0.16
    localparam logic [COEF_BITS-1:0] W_TAP1   = 16'd26214;
    localparam logic [COEF_BITS-1:0] W_TAP2   = 16'd19661;
    localparam logic [COEF_BITS-1:0] W_TAP3   = 16'd13107;
    localparam logic [COEF_BITS-1:0] W_MIX    = 16'd42598;
    localparam logic [COEF_BITS-1:0] W_BACK   = 16'd36045;
    localparam logic [COEF_BITS-1:0] W_MASTER = 16'd18350;

    localparam logic [DELAY_BITS-1:0] TAP_ONE_RESET   = 14'd3504;
    localparam logic [DELAY_BITS-1:0] TAP_TWO_RESET   = 14'd6672;
    localparam logic [DELAY_BITS-1:0] TAP_THREE_RESET = 14'd10896;
    localparam logic [COEF_BITS-1:0]  COEF_RESET      = 16'd2621;

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam int SQUELCH_INT = ((2 ** (SAMPLE_BITS - 1)) + 5000) / 10000;
    localparam logic signed [SAMPLE_BITS-1:0] SQUELCH_LEVEL = SAMPLE_BITS'(SQUELCH_INT);
    localparam logic signed [PROD_BITS-1:0]   ROUND_HALF    = PROD_BITS'(2 ** (FRAC_BITS - 1));

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_TAP_ONE,
        REG_TAP_TWO,
        REG_TAP_THREE,
        REG_FEEDBACK_COEF
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] dry_left;
        logic signed [SAMPLE_BITS-1:0] dry_right;
        logic                          sources_active;
        logic                          clear_request;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] thunder_left;
        logic signed [SAMPLE_BITS-1:0] thunder_right;
    } out_item_t;

    // microcode fields
    typedef enum logic [1:0] {TAP_NONE, TAP_ONE, TAP_TWO, TAP_THREE} tap_sel_t;
    typedef enum logic [1:0] {OPA_RDATA, OPA_DIFF, OPA_SMOOTH, OPA_MIX} opa_t;
    typedef enum logic [2:0] {
        WS_TAP1, WS_TAP2, WS_TAP3, WS_MIX, WS_BACK, WS_MASTER, WS_COEF
    } wsel_t;
    typedef enum logic [2:0] {
        POST_NONE, POST_ACC_LOAD, POST_ACC_ADD, POST_TAPSUM,
        POST_SMOOTH, POST_MIX, POST_BACK, POST_OUT
    } post_t;
    typedef enum logic [1:0] {JMP_NEXT, JMP_WAIT_IN, JMP_WAIT_OUT} jmp_t;

    localparam int PROG_LEN  = 13;
    localparam int STEP_BITS = $clog2(PROG_LEN);
    typedef logic [STEP_BITS-1:0] step_t;
    localparam step_t FIRST_STEP = '0;
    localparam step_t LAST_STEP  = step_t'(PROG_LEN - 1);

    typedef struct packed {
        tap_sel_t rd;
        logic     mul_en;
        opa_t     opa;
        wsel_t    wsel;
        post_t    post;
        jmp_t     jmp;
        step_t    target;
    } uop_t;

    // control from the sequencer to each channel datapath
    typedef struct packed {
        logic  rd_en;
        logic  hit;
        logic  mul_en;
        opa_t  opa;
        wsel_t wsel;
        post_t post;
        logic  load;
        logic  clear;
        logic  squelch;
    } lane_ctl_t;

    // fields: rd, mul_en, opa, wsel, post, jmp, target
    localparam uop_t PROGRAM [PROG_LEN] = '{
        '{TAP_NONE,  1'b0, OPA_RDATA,  WS_TAP1,   POST_NONE,     JMP_WAIT_IN,  FIRST_STEP},
        '{TAP_ONE,   1'b0, OPA_RDATA,  WS_TAP1,   POST_NONE,     JMP_NEXT,     FIRST_STEP},
        '{TAP_TWO,   1'b1, OPA_RDATA,  WS_TAP1,   POST_NONE,     JMP_NEXT,     FIRST_STEP},
        '{TAP_THREE, 1'b1, OPA_RDATA,  WS_TAP2,   POST_ACC_LOAD, JMP_NEXT,     FIRST_STEP},
        '{TAP_NONE,  1'b1, OPA_RDATA,  WS_TAP3,   POST_ACC_ADD,  JMP_NEXT,     FIRST_STEP},
        '{TAP_NONE,  1'b0, OPA_RDATA,  WS_TAP1,   POST_ACC_ADD,  JMP_NEXT,     FIRST_STEP},
        '{TAP_NONE,  1'b0, OPA_RDATA,  WS_TAP1,   POST_TAPSUM,   JMP_NEXT,     FIRST_STEP},
        '{TAP_NONE,  1'b1, OPA_DIFF,   WS_COEF,   POST_NONE,     JMP_NEXT,     FIRST_STEP},
        '{TAP_NONE,  1'b0, OPA_RDATA,  WS_TAP1,   POST_SMOOTH,   JMP_NEXT,     FIRST_STEP},
        '{TAP_NONE,  1'b1, OPA_SMOOTH, WS_MIX,    POST_NONE,     JMP_NEXT,     FIRST_STEP},
        '{TAP_NONE,  1'b1, OPA_SMOOTH, WS_BACK,   POST_MIX,      JMP_NEXT,     FIRST_STEP},
        '{TAP_NONE,  1'b1, OPA_MIX,    WS_MASTER, POST_BACK,     JMP_NEXT,     FIRST_STEP},
        '{TAP_NONE,  1'b0, OPA_RDATA,  WS_TAP1,   POST_OUT,      JMP_WAIT_OUT, FIRST_STEP}
    };

    // floor(x / 2^16 + 1/2)
    function automatic logic signed [RND_BITS-1:0] round_q16(
        input logic signed [PROD_BITS-1:0] x
    );
        logic signed [PROD_BITS-1:0] v;
        v = x + ROUND_HALF;
        return v[PROD_BITS-1:FRAC_BITS];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [SUM_BITS-1:0] v
    );
        logic signed [SUM_BITS-1:0] hi;
        logic signed [SUM_BITS-1:0] lo;
        hi = SUM_BITS'(S_MAX);
        lo = SUM_BITS'(S_MIN);
        if (v > hi) begin
            return S_MAX;
        end else if (v < lo) begin
            return S_MIN;
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

endpackage

// ===== src/smfd_lane.sv =====
`timescale 1ns / 1ps
// one channel datapath: delay memory, tap multiply-accumulate, low-pass, mix and write-back
module smfd_lane
    import smfd_pkg::*;
#(
    parameter int STORE_DEPTH = 16384
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lane_ctl_t                     ctl,
    input  logic [$clog2(STORE_DEPTH)-1:0] addr,
    input  logic signed [SAMPLE_BITS-1:0] dry,
    input  logic [COEF_BITS-1:0]          coef,
    output logic                          quiet,
    output logic signed [SAMPLE_BITS-1:0] sample_out
);

    logic signed [SAMPLE_BITS-1:0] mem [STORE_DEPTH];

    logic signed [SAMPLE_BITS-1:0] rdata_reg;
    logic signed [SAMPLE_BITS-1:0] dry_reg;
    logic signed [SAMPLE_BITS-1:0] ts_reg;
    logic signed [SAMPLE_BITS-1:0] sm_reg;
    logic signed [SAMPLE_BITS-1:0] mix_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [PROD_BITS-1:0]   acc_reg;

    logic signed [OPA_BITS-1:0]    opa;
    logic [COEF_BITS-1:0]          weight;
    logic signed [PROD_BITS-1:0]   prod_next;
    logic signed [PROD_BITS-1:0]   rnd_src;
    logic signed [RND_BITS-1:0]    rnd;
    logic signed [SAMPLE_BITS-1:0] addend;
    logic signed [SUM_BITS-1:0]    sum;
    logic signed [SAMPLE_BITS-1:0] res;

    always_comb begin
        unique case (ctl.opa)
            // a tap entry not written since the last clear reads as zero
            OPA_RDATA:  opa = ctl.hit ? OPA_BITS'(rdata_reg) : '0;
            OPA_DIFF:   opa = OPA_BITS'(ts_reg) - OPA_BITS'(sm_reg);
            OPA_SMOOTH: opa = OPA_BITS'(sm_reg);
            OPA_MIX:    opa = OPA_BITS'(mix_reg);
        endcase
    end

    always_comb begin
        unique case (ctl.wsel)
            WS_TAP1:   weight = W_TAP1;
            WS_TAP2:   weight = W_TAP2;
            WS_TAP3:   weight = W_TAP3;
            WS_MIX:    weight = W_MIX;
            WS_BACK:   weight = W_BACK;
            WS_MASTER: weight = W_MASTER;
            WS_COEF:   weight = coef;
            default:   weight = '0;
        endcase
    end

    assign prod_next = opa * signed'({1'b0, weight});

    always_comb begin
        rnd_src = (ctl.post == POST_TAPSUM) ? acc_reg : prod_reg;
        rnd     = round_q16(rnd_src);
        unique case (ctl.post)
            POST_SMOOTH:         addend = sm_reg;
            POST_MIX, POST_BACK: addend = dry_reg;
            default:             addend = '0;
        endcase
        sum = SUM_BITS'(rnd) + SUM_BITS'(addend);
        res = sat_sample(sum);
    end

    always_ff @(posedge aclk) begin
        if (ctl.post == POST_BACK) begin
            mem[addr] <= res;
        end
        if (ctl.rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            dry_reg <= dry;
        end
        if (ctl.mul_en) begin
            prod_reg <= prod_next;
        end
        unique case (ctl.post)
            POST_ACC_LOAD: acc_reg <= prod_reg;
            POST_ACC_ADD:  acc_reg <= acc_reg + prod_reg;
            POST_TAPSUM:   ts_reg  <= res;
            POST_MIX:      mix_reg <= res;
            POST_OUT:      out_reg <= res;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sm_reg <= '0;
        end else if (ctl.clear || ctl.squelch) begin
            sm_reg <= '0;
        end else if (ctl.post == POST_SMOOTH) begin
            sm_reg <= res;
        end
    end

    assign quiet      = (sm_reg < SQUELCH_LEVEL) && (sm_reg > -SQUELCH_LEVEL);
    assign sample_out = out_reg;

endmodule

// ===== src/stereo_multitap_feedback_delay.sv =====
`timescale 1ns / 1ps
// top level: sequencer, configuration, write position and output register of the stereo echo
//
// One stereo Q1.23 sample enters per transfer on s_valid/s_ready (s_data), one mixed stereo
// sample leaves per transfer on m_valid/m_ready (m_data). Tap distances and the feedback
// low-pass coefficient are written on cfg_valid/cfg_ready (cfg_index, cfg_data), always ready.
// An accepted sample runs through a 13-step microcode program that drives one multiplier and
// one single-port delay memory per channel; a new sample is taken only once the program has
// run through for the last one and handed its result on. The three tap reads on the memory
// port and the multiplies that follow each other through the filter set the program length.
// Reset restores the default tap distances and coefficient and empties both delay lines at
// once: a wrap flag and the write position tell which entries were written since the last
// clear, and older entries read as zero, so there is no clearing pass. A clear request on an
// input sample empties the lines the same way before that sample is processed.
// The result sits in an output register; while the receiver stalls the next sample is still
// taken and processed, and its result waits at the last program step until the output
// register frees up.
module stereo_multitap_feedback_delay
    import smfd_pkg::*;
#(
    parameter int STORE_DEPTH = 16384
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  in_item_t                  s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output out_item_t                 m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int ADDR_BITS = $clog2(STORE_DEPTH);
    localparam int RED_BITS  = ADDR_BITS + 4;
    localparam logic [ADDR_BITS:0]   DEPTH_W = (ADDR_BITS + 1)'(STORE_DEPTH);
    localparam logic [ADDR_BITS-1:0] WP_LAST = ADDR_BITS'(STORE_DEPTH - 1);

    // delay modulo depth; the quotient stays below 16 for a depth of 1024 or more
    function automatic logic [ADDR_BITS-1:0] wrap_delay(input logic [DELAY_BITS-1:0] d);
        logic [RED_BITS-1:0] r;
        r = RED_BITS'(d);
        for (int k = 3; k >= 0; k--) begin
            if (r >= (RED_BITS'(STORE_DEPTH) << k)) begin
                r = r - (RED_BITS'(STORE_DEPTH) << k);
            end
        end
        return r[ADDR_BITS-1:0];
    endfunction

    step_t                  pc_reg, pc_next;
    logic [ADDR_BITS-1:0]   wp_reg;
    logic                   wrapped_reg;
    logic                   m_valid_reg;
    logic                   hit_reg;
    logic                   active_reg;
    logic [ADDR_BITS-1:0]   dly1_reg, dly2_reg, dly3_reg;
    logic [COEF_BITS-1:0]   coef_reg;

    uop_t                   uop;
    logic                   accept;
    logic                   out_free;
    logic                   release_out;
    logic                   squelch;
    logic [ADDR_BITS-1:0]   dsel;
    logic [ADDR_BITS:0]     diff;
    logic [ADDR_BITS:0]     diff_wrap;
    logic [ADDR_BITS-1:0]   tap_idx;
    logic                   tap_hit;
    logic [ADDR_BITS-1:0]   mem_addr;
    lane_ctl_t              ctl;
    logic                   quiet_l, quiet_r;
    logic signed [SAMPLE_BITS-1:0] out_l, out_r;

    assign uop         = PROGRAM[pc_reg];
    assign s_ready     = (uop.jmp == JMP_WAIT_IN);
    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign release_out = (uop.jmp == JMP_WAIT_OUT) && out_free;
    assign squelch     = release_out && !active_reg && quiet_l && quiet_r;
    assign cfg_ready   = 1'b1;

    // step counter
    always_comb begin
        pc_next = pc_reg;
        unique case (uop.jmp)
            JMP_NEXT:     pc_next = pc_reg + 1'b1;
            JMP_WAIT_IN:  if (s_valid) pc_next = pc_reg + 1'b1;
            JMP_WAIT_OUT: if (out_free) pc_next = uop.target;
            default:      pc_next = FIRST_STEP;
        endcase
    end

    // tap address behind the write position, and whether that entry holds live data
    always_comb begin
        unique case (uop.rd)
            TAP_NONE, TAP_ONE: dsel = dly1_reg;
            TAP_TWO:           dsel = dly2_reg;
            TAP_THREE:         dsel = dly3_reg;
        endcase
        diff      = {1'b0, wp_reg} - {1'b0, dsel};
        diff_wrap = diff + DEPTH_W;
        tap_idx   = diff[ADDR_BITS] ? diff_wrap[ADDR_BITS-1:0] : diff[ADDR_BITS-1:0];
        tap_hit   = wrapped_reg || (tap_idx < wp_reg);
        mem_addr  = (uop.post == POST_BACK) ? wp_reg : tap_idx;
    end

    always_comb begin
        ctl.rd_en   = (uop.rd != TAP_NONE);
        ctl.hit     = hit_reg;
        ctl.mul_en  = uop.mul_en;
        ctl.opa     = uop.opa;
        ctl.wsel    = uop.wsel;
        ctl.post    = (uop.post == POST_OUT && !out_free) ? POST_NONE : uop.post;
        ctl.load    = accept;
        ctl.clear   = accept && s_data.clear_request;
        ctl.squelch = squelch;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= FIRST_STEP;
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            dly1_reg    <= wrap_delay(TAP_ONE_RESET);
            dly2_reg    <= wrap_delay(TAP_TWO_RESET);
            dly3_reg    <= wrap_delay(TAP_THREE_RESET);
            coef_reg    <= COEF_RESET;
        end else begin
            pc_reg <= pc_next;
            if (accept && s_data.clear_request) begin
                wp_reg      <= '0;
                wrapped_reg <= 1'b0;
            end else if (release_out) begin
                if (wp_reg == WP_LAST) begin
                    wp_reg      <= '0;
                    wrapped_reg <= 1'b1;
                end else begin
                    wp_reg <= wp_reg + 1'b1;
                end
            end
            if (release_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_TAP_ONE:       dly1_reg <= wrap_delay(cfg_data[DELAY_BITS-1:0]);
                    REG_TAP_TWO:       dly2_reg <= wrap_delay(cfg_data[DELAY_BITS-1:0]);
                    REG_TAP_THREE:     dly3_reg <= wrap_delay(cfg_data[DELAY_BITS-1:0]);
                    REG_FEEDBACK_COEF: coef_reg <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            hit_reg <= tap_hit;
        end
        if (accept) begin
            active_reg <= s_data.sources_active;
        end
    end

    smfd_lane #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_lane_left (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .addr      (mem_addr),
        .dry       (s_data.dry_left),
        .coef      (coef_reg),
        .quiet     (quiet_l),
        .sample_out(out_l)
    );

    smfd_lane #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_lane_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .addr      (mem_addr),
        .dry       (s_data.dry_right),
        .coef      (coef_reg),
        .quiet     (quiet_r),
        .sample_out(out_r)
    );

    assign m_valid              = m_valid_reg;
    assign m_data.thunder_left  = out_l;
    assign m_data.thunder_right = out_r;

    // an accepted sample starts the program at the first tap read
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (pc_reg == step_t'(FIRST_STEP + 1'b1)))
        else $error("program did not start after input transfer");

    // a result appears only when the last step hands it over
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(pc_reg) == LAST_STEP))
        else $error("result valid raised outside the last program step");

    // the single memory port never reads and writes in one cycle
    a_port_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.rd_en |-> (ctl.post != POST_BACK))
        else $error("memory read and write in the same cycle");

    // the wrap flag is set only as the write position returns to zero
    a_wrap_at_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(wrapped_reg) |-> (wp_reg == '0))
        else $error("wrap flag set away from position zero");

    // the write position moves at most one entry per cycle, or back to zero
    a_wp_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(wp_reg) |-> ((wp_reg == '0) || (wp_reg == $past(wp_reg) + 1'b1)))
        else $error("write position skipped");

endmodule

// ===== verif/tb_stereo_multitap_feedback_delay.sv =====
`timescale 1ns / 1ps
// testbench for the stereo echo: directed and random samples checked against a bit-exact predictor
module tb_stereo_multitap_feedback_delay;
    import smfd_pkg::*;

    localparam int DEPTH  = 16384;
    localparam int SETTLE = 30;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_item_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_item_t m_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    always #5 aclk = ~aclk;

    stereo_multitap_feedback_delay dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state: index 0 is left, 1 is right
    logic signed [SAMPLE_BITS-1:0] echo_mem [2][DEPTH];
    logic [DELAY_BITS-1:0]         wr_pos;
    longint                        smooth_st [2];
    logic [DELAY_BITS-1:0]         tap_d [3];
    logic [COEF_BITS-1:0]          fb_coef;

    out_item_t due_mix [$];
    int        errors = 0;
    bit        calm   = 1'b0;
    int        rx_hold = 0;

    function automatic int pick_gap();
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // floor(x / 2^16 + 1/2)
    function automatic longint rnd_q16(longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clip24(longint v);
        if (v > longint'(S_MAX)) return longint'(S_MAX);
        if (v < longint'(S_MIN)) return longint'(S_MIN);
        return v;
    endfunction

    task automatic clear_lines();
        for (int i = 0; i < DEPTH; i++) begin
            echo_mem[0][i] = '0;
            echo_mem[1][i] = '0;
        end
        wr_pos       = '0;
        smooth_st[0] = 0;
        smooth_st[1] = 0;
    endtask

    function automatic longint run_lane(int ch, longint dry, logic [DELAY_BITS-1:0] i1,
                                        logic [DELAY_BITS-1:0] i2, logic [DELAY_BITS-1:0] i3);
        longint taps;
        longint tsum;
        longint sm;
        longint mix;
        taps = longint'(echo_mem[ch][i1]) * longint'(W_TAP1)
             + longint'(echo_mem[ch][i2]) * longint'(W_TAP2)
             + longint'(echo_mem[ch][i3]) * longint'(W_TAP3);
        tsum = clip24(rnd_q16(taps));
        sm = clip24(smooth_st[ch] + rnd_q16(longint'(fb_coef) * (tsum - smooth_st[ch])));
        smooth_st[ch] = sm;
        mix = clip24(dry + rnd_q16(sm * longint'(W_MIX)));
        echo_mem[ch][wr_pos] = SAMPLE_BITS'(clip24(dry + rnd_q16(sm * longint'(W_BACK))));
        return clip24(rnd_q16(mix * longint'(W_MASTER)));
    endfunction

    task automatic predict_echo(input in_item_t it, output out_item_t r);
        logic [DELAY_BITS-1:0] i1;
        logic [DELAY_BITS-1:0] i2;
        logic [DELAY_BITS-1:0] i3;
        longint ol;
        longint orr;
        longint sq;
        if (it.clear_request) clear_lines();
        // 14-bit subtraction wraps around the store
        i1 = wr_pos - tap_d[0];
        i2 = wr_pos - tap_d[1];
        i3 = wr_pos - tap_d[2];
        ol  = run_lane(0, longint'(it.dry_left), i1, i2, i3);
        orr = run_lane(1, longint'(it.dry_right), i1, i2, i3);
        wr_pos = wr_pos + 1'b1;
        sq = longint'(SQUELCH_LEVEL);
        if (!it.sources_active && smooth_st[0] < sq && smooth_st[0] > -sq
                && smooth_st[1] < sq && smooth_st[1] > -sq) begin
            smooth_st[0] = 0;
            smooth_st[1] = 0;
        end
        r.thunder_left  = ol[SAMPLE_BITS-1:0];
        r.thunder_right = orr[SAMPLE_BITS-1:0];
    endtask

    function automatic in_item_t mk(logic signed [SAMPLE_BITS-1:0] l,
                                    logic signed [SAMPLE_BITS-1:0] r, logic act, logic clr);
        in_item_t it;
        it.dry_left       = l;
        it.dry_right      = r;
        it.sources_active = act;
        it.clear_request  = clr;
        return it;
    endfunction

    task automatic send_sample(input in_item_t it);
        int gap;
        out_item_t r;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_echo(it, r);
        due_mix.push_back(r);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (due_mix.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
        wait_idle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_TAP_ONE:       tap_d[0] = val[DELAY_BITS-1:0];
            REG_TAP_TWO:       tap_d[1] = val[DELAY_BITS-1:0];
            REG_TAP_THREE:     tap_d[2] = val[DELAY_BITS-1:0];
            REG_FEEDBACK_COEF: fb_coef  = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_taps(input logic [CFG_DATA_BITS-1:0] t1, input logic [CFG_DATA_BITS-1:0] t2,
                            input logic [CFG_DATA_BITS-1:0] t3, input logic [CFG_DATA_BITS-1:0] c);
        write_reg(REG_TAP_ONE, t1);
        write_reg(REG_TAP_TWO, t2);
        write_reg(REG_TAP_THREE, t3);
        write_reg(REG_FEEDBACK_COEF, c);
    endtask

    // receiver side stalls
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            m_ready <= 1'b1;
            rx_hold = pick_gap();
        end
    end

    task automatic report(input string what, input logic [SAMPLE_BITS-1:0] want,
                          input logic [SAMPLE_BITS-1:0] got);
        errors++;
        if (errors <= 10) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $realtime, what,
                     $signed(want), $signed(got));
        end
    endtask

    always @(posedge aclk) begin : check_mix
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_mix.size() == 0) begin
                report("unexpected transfer, left", '0, m_data.thunder_left);
            end else begin
                want = due_mix.pop_front();
                if (want.thunder_left !== m_data.thunder_left)
                    report("thunder_left", want.thunder_left, m_data.thunder_left);
                if (want.thunder_right !== m_data.thunder_right)
                    report("thunder_right", want.thunder_right, m_data.thunder_right);
            end
        end
    end

    task automatic test_reset_values();
        send_sample(mk(S_MAX, S_MIN, 1'b1, 1'b0));
        send_sample(mk(S_MIN, S_MAX, 1'b1, 1'b0));
        send_sample(mk('0, '0, 1'b0, 1'b0));
        send_sample(mk(-24'sd1, 24'sd1, 1'b1, 1'b0));
        send_sample(mk(24'sh555555, 24'shAAAAAA, 1'b0, 1'b0));
    endtask

    // short taps and full feedback drive the sums into saturation
    task automatic test_saturation();
        set_taps(16'd1, 16'd2, 16'd3, 16'hFFFF);
        repeat (4) send_sample(mk(S_MAX, S_MIN, 1'b1, 1'b0));
        repeat (2) send_sample(mk(S_MIN, S_MAX, 1'b1, 1'b0));
        repeat (2) send_sample(mk('0, '0, 1'b0, 1'b0));
    endtask

    // small signal decays under the squelch level only while no source is active
    task automatic test_clear_and_squelch();
        send_sample(mk(24'sd2000, -24'sd2000, 1'b1, 1'b1));
        send_sample(mk('0, '0, 1'b1, 1'b0));
        send_sample(mk('0, '0, 1'b0, 1'b0));
        send_sample(mk(24'sd700, -24'sd700, 1'b0, 1'b1));
    endtask

    // zero delay reads the oldest entry, upper data bits are dropped
    task automatic test_odd_taps();
        set_taps(16'h0000, 16'hFFFF, 16'hC005, 16'd1);
        send_sample(mk(S_MAX, S_MAX, 1'b1, 1'b0));
        send_sample(mk(S_MIN, 24'sd12345, 1'b1, 1'b0));
        send_sample(mk(24'sd4096, S_MIN, 1'b0, 1'b0));
        send_sample(mk('0, '0, 1'b0, 1'b1));
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] rand_delay();
        int roll;
        logic [DELAY_BITS-1:0] d;
        roll = $urandom_range(0, 99);
        if (roll < 80) d = DELAY_BITS'($urandom_range(1, 48));
        else if (roll < 90) d = DELAY_BITS'($urandom);
        else d = DELAY_BITS'($urandom_range(0, 3));
        return {2'($urandom), d};
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] rand_coef(int phase);
        if (phase == 1) return 16'hFFFF;
        if (phase == 2) return 16'h0000;
        return CFG_DATA_BITS'($urandom);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rand_dry(int kind);
        int v;
        case (kind)
            0: return SAMPLE_BITS'($urandom);
            1: begin
                v = int'($urandom_range(0, 8191)) - 4096;
                return v[SAMPLE_BITS-1:0];
            end
            default: begin
                v = int'($urandom_range(0, 15)) - 8;
                return v[SAMPLE_BITS-1:0];
            end
        endcase
    endfunction

    // segments of loud, soft and quiet passages, quiet ones let the feedback die out
    task automatic test_random();
        int kind;
        int seg;
        int n;
        logic act;
        logic clr;
        for (int phase = 0; phase < 8; phase++) begin
            set_taps(rand_delay(), rand_delay(), rand_delay(), rand_coef(phase));
            calm = (phase == 3);
            n = 0;
            while (n < 150) begin
                kind = $urandom_range(0, 2);
                seg  = $urandom_range(5, 30);
                repeat (seg) begin
                    act = (kind == 2) ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 9) != 0);
                    clr = ($urandom_range(0, 199) == 0);
                    send_sample(mk(rand_dry(kind), rand_dry(kind), act, clr));
                    n++;
                end
            end
            calm = 1'b0;
        end
    endtask

    initial begin
        tap_d[0] = TAP_ONE_RESET;
        tap_d[1] = TAP_TWO_RESET;
        tap_d[2] = TAP_THREE_RESET;
        fb_coef  = COEF_RESET;
        clear_lines();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_values();
        test_saturation();
        test_clear_and_squelch();
        test_odd_taps();
        test_random();
        wait_idle();
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
